### src/ctok_pkg.sv
// Shared definitions for the C token scanner: token kind codes, scanner modes,
// operator rule table, character classes and the keyword spellings.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ctok_pkg;

	localparam int KIND_BITS       = 6;
	localparam int LINE_BITS       = 24;
	localparam int OFFSET_BITS_DEF = 24;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [2:0] KW_NONE    = 3'd7;
	localparam logic [2:0] KW_FIRST   = 3'd1;
	localparam logic [2:0] KW_INT_LEN = 3'd3;
	localparam logic [2:0] KW_RET_LEN = 3'd6;

	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	typedef enum logic [KIND_BITS-1:0] {
		TK_SEMI = 6'd0, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE,
		TK_DEC, TK_SUB_ASSIGN, TK_MINUS, TK_INC, TK_ADD_ASSIGN, TK_PLUS,
		TK_MUL_ASSIGN, TK_STAR, TK_DIV_ASSIGN, TK_SLASH, TK_MOD_ASSIGN, TK_PERCENT,
		TK_XOR_ASSIGN, TK_CARET, TK_OR_ASSIGN, TK_LOR, TK_BOR,
		TK_AND_ASSIGN, TK_LAND, TK_BAND, TK_TILDE_ASSIGN, TK_TILDE,
		TK_NE, TK_NOT, TK_EQ, TK_ASSIGN, TK_GE, TK_SHR_ASSIGN, TK_SHR, TK_GT,
		TK_LE, TK_SHL_ASSIGN, TK_SHL, TK_LT, TK_INT, TK_RETURN, TK_IDENT,
		TK_NUMBER, TK_EOF, TK_BAD_CHAR, TK_DIRECTIVE
	} tok_kind_t;

	typedef enum logic [4:0] {
		M_IDLE = 5'd0, M_MINUS, M_PLUS, M_STAR, M_SLASH, M_PERCENT, M_CARET,
		M_BAR, M_AMP, M_TILDE, M_BANG, M_EQUAL, M_GT, M_SHR, M_LT, M_SHL,
		M_ID_INT, M_ID_RET, M_ID, M_NUM, M_DIR
	} mode_t;

	// How a pending operator reacts to the next byte
	typedef struct packed {
		logic [7:0] c1;
		tok_kind_t  k1;
		logic       has_c2;
		logic [7:0] c2;
		logic       go_next;
		tok_kind_t  k2;
		tok_kind_t  single;
	} op_rule_t;

	function automatic op_rule_t op_rule(input mode_t m);
		op_rule_t r;
		r = '{c1: "=", k1: TK_ASSIGN, has_c2: 1'b0, c2: "=", go_next: 1'b0,
			k2: TK_ASSIGN, single: TK_ASSIGN};
		case (m)
			M_MINUS: begin
				r.c1 = "-"; r.k1 = TK_DEC; r.has_c2 = 1'b1; r.c2 = "=";
				r.k2 = TK_SUB_ASSIGN; r.single = TK_MINUS;
			end
			M_PLUS: begin
				r.c1 = "+"; r.k1 = TK_INC; r.has_c2 = 1'b1; r.c2 = "=";
				r.k2 = TK_ADD_ASSIGN; r.single = TK_PLUS;
			end
			M_STAR: begin
				r.k1 = TK_MUL_ASSIGN; r.single = TK_STAR;
			end
			M_SLASH: begin
				r.k1 = TK_DIV_ASSIGN; r.single = TK_SLASH;
			end
			M_PERCENT: begin
				r.k1 = TK_MOD_ASSIGN; r.single = TK_PERCENT;
			end
			M_CARET: begin
				r.k1 = TK_XOR_ASSIGN; r.single = TK_CARET;
			end
			M_BAR: begin
				r.k1 = TK_OR_ASSIGN; r.has_c2 = 1'b1; r.c2 = "|";
				r.k2 = TK_LOR; r.single = TK_BOR;
			end
			M_AMP: begin
				r.k1 = TK_AND_ASSIGN; r.has_c2 = 1'b1; r.c2 = "&";
				r.k2 = TK_LAND; r.single = TK_BAND;
			end
			M_TILDE: begin
				r.k1 = TK_TILDE_ASSIGN; r.single = TK_TILDE;
			end
			M_BANG: begin
				r.k1 = TK_NE; r.single = TK_NOT;
			end
			M_EQUAL: begin
				r.k1 = TK_EQ; r.single = TK_ASSIGN;
			end
			M_GT: begin
				r.k1 = TK_GE; r.has_c2 = 1'b1; r.c2 = ">"; r.go_next = 1'b1;
				r.single = TK_GT;
			end
			M_SHR: begin
				r.k1 = TK_SHR_ASSIGN; r.single = TK_SHR;
			end
			M_LT: begin
				r.k1 = TK_LE; r.has_c2 = 1'b1; r.c2 = "<"; r.go_next = 1'b1;
				r.single = TK_LT;
			end
			M_SHL: begin
				r.k1 = TK_SHL_ASSIGN; r.single = TK_SHL;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic [7:0] kw_int_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = "i";
			3'd1:    c = "n";
			3'd2:    c = "t";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_ret_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = "r";
			3'd1:    c = "e";
			3'd2:    c = "t";
			3'd3:    c = "u";
			3'd4:    c = "r";
			3'd5:    c = "n";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Result fields packed from bit 0 up, rounded to whole bytes
	function automatic int tdata_bits(input int ob, input int lb);
		return ((KIND_BITS + ob + lb + LINE_BITS + 7) / 8) * 8;
	endfunction

endpackage

`default_nettype wire

### src/ctok_core.sv
// Scanner state and the per-byte decision logic: emits up to two packed
// result words for each accepted input word. Depends on ctok_pkg.
`default_nettype none

module ctok_core import ctok_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int TDATA_BITS  = tdata_bits(OFFSET_BITS_DEF, LENGTH_BITS_DEF)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire logic                  is_eof,
	input  wire logic [7:0]            ch,
	output logic      [1:0]            push_n,
	output logic      [TDATA_BITS:0]   res0,
	output logic      [TDATA_BITS:0]   res1
);

	localparam int DATA_BITS = KIND_BITS + OFFSET_BITS + LENGTH_BITS + LINE_BITS;

	mode_t                  mode_q, mode_d;
	logic [2:0]             kw_q, kw_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, start_q, start_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LINE_BITS-1:0]   line_q, line_d;

	op_rule_t               rule;
	logic                   is_op, hit_c1, hit_c2, extend, pending, op_done;
	logic [LENGTH_BITS-1:0] len_inc;
	logic [OFFSET_BITS-1:0] off_inc;
	logic [LINE_BITS-1:0]   line_inc;
	tok_kind_t              pend_kind;
	logic [2:0]             kw_adv;

	logic                   fr_emit, fr_nl;
	tok_kind_t              fr_kind;
	mode_t                  fr_mode;

	logic                   a_valid, b_valid;
	tok_kind_t              a_kind, b_kind;
	logic [OFFSET_BITS-1:0] a_start, b_start;
	logic [LENGTH_BITS-1:0] a_len, b_len;
	logic [DATA_BITS-1:0]   a_data, b_data;

	assign len_inc  = (len_q == '1) ? len_q : len_q + LENGTH_BITS'(1);
	assign off_inc  = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

	assign rule    = op_rule(mode_q);
	assign is_op   = mode_q inside {[M_MINUS:M_SHL]};
	assign pending = (mode_q != M_IDLE);
	assign hit_c1  = is_op && (ch == rule.c1);
	assign hit_c2  = is_op && !hit_c1 && rule.has_c2 && (ch == rule.c2);
	assign op_done = !is_eof && (hit_c1 || (hit_c2 && !rule.go_next));

	// Does this byte continue the pending token?
	always_comb begin
		case (mode_q)
			M_ID_INT, M_ID_RET, M_ID, M_DIR: extend = is_ident(ch);
			M_NUM:                           extend = is_digit(ch);
			default:                         extend = hit_c1 || hit_c2;
		endcase
		extend = extend && !is_eof;
	end

	always_comb begin
		case (mode_q)
			M_ID_INT: pend_kind = (kw_q == KW_INT_LEN) ? TK_INT : TK_IDENT;
			M_ID_RET: pend_kind = (kw_q == KW_RET_LEN) ? TK_RETURN : TK_IDENT;
			M_ID:     pend_kind = TK_IDENT;
			M_NUM:    pend_kind = TK_NUMBER;
			M_DIR:    pend_kind = TK_DIRECTIVE;
			default:  pend_kind = rule.single;
		endcase
	end

	always_comb begin
		case (mode_q)
			M_ID_INT: kw_adv = (kw_q < KW_INT_LEN && ch == kw_int_char(kw_q)) ?
				kw_q + 3'd1 : KW_NONE;
			M_ID_RET: kw_adv = (kw_q < KW_RET_LEN && ch == kw_ret_char(kw_q)) ?
				kw_q + 3'd1 : KW_NONE;
			default:  kw_adv = KW_NONE;
		endcase
	end

	// Classify a byte that starts something new
	always_comb begin
		fr_emit = 1'b0;
		fr_kind = TK_BAD_CHAR;
		fr_mode = M_IDLE;
		fr_nl   = 1'b0;
		case (ch)
			" ", CH_TAB: begin
			end
			CH_LF: fr_nl = 1'b1;
			";": begin fr_emit = 1'b1; fr_kind = TK_SEMI;   end
			"(": begin fr_emit = 1'b1; fr_kind = TK_LPAREN; end
			")": begin fr_emit = 1'b1; fr_kind = TK_RPAREN; end
			"{": begin fr_emit = 1'b1; fr_kind = TK_LBRACE; end
			"}": begin fr_emit = 1'b1; fr_kind = TK_RBRACE; end
			"-": fr_mode = M_MINUS;
			"+": fr_mode = M_PLUS;
			"*": fr_mode = M_STAR;
			"/": fr_mode = M_SLASH;
			"%": fr_mode = M_PERCENT;
			"^": fr_mode = M_CARET;
			"|": fr_mode = M_BAR;
			"&": fr_mode = M_AMP;
			"~": fr_mode = M_TILDE;
			"!": fr_mode = M_BANG;
			"=": fr_mode = M_EQUAL;
			">": fr_mode = M_GT;
			"<": fr_mode = M_LT;
			"#": fr_mode = M_DIR;
			default: begin
				if (is_alpha(ch) || ch == CH_UNDERSCORE) begin
					fr_mode = (ch == "i") ? M_ID_INT : ((ch == "r") ? M_ID_RET : M_ID);
				end else if (is_digit(ch)) begin
					fr_mode = M_NUM;
				end else begin
					fr_emit = 1'b1;
				end
			end
		endcase
	end

	// Next state
	always_comb begin
		mode_d  = mode_q;
		kw_d    = kw_q;
		off_d   = off_q;
		start_d = start_q;
		len_d   = len_q;
		line_d  = line_q;
		if (fire) begin
			if (is_eof) begin
				mode_d  = M_IDLE;
				kw_d    = KW_NONE;
				off_d   = '0;
				start_d = '0;
				len_d   = '0;
				line_d  = '0;
			end else begin
				off_d = off_inc;
				if (extend) begin
					len_d = len_inc;
					if (is_op) begin
						mode_d = op_done ? M_IDLE : mode_t'(mode_q + 5'd1);
					end else begin
						kw_d = kw_adv;
					end
				end else begin
					mode_d = fr_mode;
					kw_d   = KW_NONE;
					if (fr_mode != M_IDLE) begin
						start_d = off_q;
						len_d   = LENGTH_BITS'(1);
						if (fr_mode == M_ID_INT || fr_mode == M_ID_RET) begin
							kw_d = KW_FIRST;
						end
					end
					if (fr_nl) begin
						line_d = line_inc;
					end
				end
			end
		end
	end

	// Results: the finished or flushed token first, then the one this byte makes
	always_comb begin
		if (is_eof) begin
			a_valid = pending;
			a_kind  = pend_kind;
			a_start = start_q;
			a_len   = len_q;
			b_valid = 1'b1;
			b_kind  = TK_EOF;
			b_len   = '0;
		end else begin
			a_valid = op_done || (pending && !extend);
			a_kind  = op_done ? (hit_c1 ? rule.k1 : rule.k2) : pend_kind;
			a_start = start_q;
			a_len   = op_done ? len_inc : len_q;
			b_valid = !extend && fr_emit;
			b_kind  = fr_kind;
			b_len   = LENGTH_BITS'(1);
		end
		b_start = off_q;
		a_data  = {line_q, a_len, a_start, a_kind};
		b_data  = {line_q, b_len, b_start, b_kind};
		push_n  = fire ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;
		res1    = {1'b1, TDATA_BITS'(b_data)};
		res0    = a_valid ? {!b_valid, TDATA_BITS'(a_data)} : res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			kw_q    <= KW_NONE;
			off_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			line_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			kw_q    <= kw_d;
			off_q   <= off_d;
			start_q <= start_d;
			len_q   <= len_d;
			line_q  <= line_d;
		end
	end

`ifndef SYNTHESIS
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_eof |=> mode_q == M_IDLE && off_q == '0 && line_q == '0)
		else $error("state not cleared after end of input");

	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_eof |-> push_n != 2'd0)
		else $error("end of input produced no result");

	a_byte_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !is_eof |=> off_q != '0)
		else $error("byte offset did not advance");

	a_push_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results for one word");
`endif

endmodule

`default_nettype wire

### src/ctok_queue.sv
// Small result queue that takes zero, one or two words per cycle and
// drains one word per cycle, while out_ready is high, to the output stream. Depends on ctok_pkg.
`default_nettype none

module ctok_queue import ctok_pkg::*; #(
	parameter int ENTRY_BITS = tdata_bits(OFFSET_BITS_DEF, LENGTH_BITS_DEF) + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [1:0]            push_n,
	input  wire logic [ENTRY_BITS-1:0] din0,
	input  wire logic [ENTRY_BITS-1:0] din1,
	output logic                       room,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [ENTRY_BITS-1:0] dout
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = PTR_BITS + 1;

	logic [ENTRY_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_ptr_q];
	// Leave space for the two words one input word may cause
	assign room      = (count_q <= CNT_BITS'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_BITS'(1)] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_BITS'(pop);
			count_q  <= count_q + CNT_BITS'(push_n) - CNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q <= CNT_BITS'(QUEUE_DEPTH - 2))
		else $error("push while queue lacks room for two words");

	a_drain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - CNT_BITS'(1))
		else $error("queue count wrong after drain");
`endif

endmodule

`default_nettype wire

### src/c_token_scanner.sv
// C token scanner (maximal munch): source bytes in, tokens out.
// Input stream: s_tdata[7:0] = source byte, s_tuser[0] = 1 marks end of input
// (byte ignored). Output stream: one token per word, m_tlast on the last token
// caused by one input word.
// Each end-of-input word flushes the pending token, emits an end-of-file token
// at the offset after the last byte and returns the scanner to its reset state.
// Tokens are registered in the result queue before they reach the output.
// One input word is taken per cycle; a word may yield zero, one or two tokens,
// and the output drains one token per cycle while m_tready is high, so
// sustained input rate is one word per cycle except while the four-entry
// result queue holds three or more words.
// s_tready depends only on the queue fill, so a stalled receiver holds the
// queue and stops input once the queue holds three or more words; nothing is dropped.
// Reset (arst_n low) empties the queue and clears offset, line count and the
// pending token.
// Depends on ctok_pkg, ctok_core and ctok_queue.
`default_nettype none

module c_token_scanner import ctok_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	input  wire logic [7:0]                                 s_tdata,  // ch
	input  wire logic [0:0]                                 s_tuser,  // kind
	output logic                                            m_tvalid,
	input  wire logic                                       m_tready,
	// token_kind, start_offset, token_len, line_no, zero fill
	output logic      [tdata_bits(OFFSET_BITS, LENGTH_BITS)-1:0] m_tdata,
	output logic                                            m_tlast
);

	localparam int TDATA_BITS = tdata_bits(OFFSET_BITS, LENGTH_BITS);

	logic                  fire;
	logic [1:0]            push_n;
	logic [TDATA_BITS:0]   res0, res1, head;

	assign fire = s_tvalid && s_tready;

	ctok_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.TDATA_BITS  (TDATA_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.is_eof (s_tuser[0]),
		.ch     (s_tdata),
		.push_n (push_n),
		.res0   (res0),
		.res1   (res1)
	);

	ctok_queue #(
		.ENTRY_BITS (TDATA_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.din0      (res0),
		.din1      (res1),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (head)
	);

	assign m_tdata = head[TDATA_BITS-1:0];
	assign m_tlast = head[TDATA_BITS];

endmodule

`default_nettype wire
